@@ design/assert_macros.svh @@
// assertion helpers used by cache_way_lock_table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define CWL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cwl assertion failed");

// checked on every rising edge
`define CWL_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("cwl assertion failed");

`endif

@@ design/cwl_pkg.sv @@
package cwl_pkg;

  localparam int NUM_SETS = 16;
  localparam int NUM_WAYS = 4;
  localparam int SET_W    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WAY_W    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int CNT_W    = $clog2(NUM_WAYS + 1);
  localparam int ADDR_W   = 40;
  localparam int ROW_W    = NUM_WAYS * (1 + ADDR_W);

  localparam logic [ADDR_W-1:0] ADDR_MASK = 40'hFF_FFFF_FFC0;

  localparam logic [2:0] MODE_LOCK   = 3'd0;
  localparam logic [2:0] MODE_UNLOCK = 3'd1;
  localparam logic [2:0] MODE_EVICT  = 3'd2;
  localparam logic [2:0] MODE_FLUSH  = 3'd3;
  localparam logic [2:0] MODE_CHANGE = 3'd4;

  localparam logic [1:0] DEST_L1  = 2'd0;
  localparam logic [1:0] DEST_L2  = 2'd1;
  localparam logic [1:0] DEST_L3  = 2'd2;
  localparam logic [1:0] DEST_MEM = 2'd3;

  localparam logic [1:0] CFG_BASE  = 2'd0;
  localparam logic [1:0] CFG_LIMIT = 2'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOCK,
    S_UNLK,
    S_WALK,
    S_FIN
  } state_t;

  typedef struct packed {
    logic              op_done;
    logic [3:0]        op_set;
    logic [1:0]        op_way;
    logic [ADDR_W-1:0] fault_address;
    logic              bus_error;
    logic              access_error;
    logic              lock_error;
    logic              clear_scratchpad;
  } res_t;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] limit;
  } cfg_t;

endpackage

@@ design/cwl_ram.sv @@
module cwl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/cwl_ctrl.sv @@
module cwl_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    in_mode,
  input  logic [3:0]                    in_set,
  input  logic [1:0]                    in_way,
  input  logic [39:0]                   in_line_addr,
  input  logic                          in_access_ok,
  input  logic                          in_write_ok,
  input  logic [1:0]                    in_dest,
  input  logic [3:0]                    in_count_minus_one,
  input  logic                          in_use_mask,
  input  logic [15:0]                   in_lane_mask,
  input  logic                          in_service_proc,
  input  logic [1:0]                    in_new_cache_mode,
  input  cwl_pkg::cfg_t                 cfg,
  output logic                          ram_we,
  output logic [cwl_pkg::SET_W-1:0]     ram_waddr,
  output logic [cwl_pkg::ROW_W-1:0]     ram_wdata,
  output logic [cwl_pkg::SET_W-1:0]     ram_raddr,
  input  logic [cwl_pkg::ROW_W-1:0]     ram_rdata,
  output logic                          out_valid,
  output logic                          out_last,
  output cwl_pkg::res_t                 out_res
);

  cwl_pkg::state_t state_r, state_nxt;

  logic [cwl_pkg::SET_W-1:0]  s_r, s_nxt;
  logic [cwl_pkg::WAY_W-1:0]  w_r, w_nxt;
  logic [cwl_pkg::ADDR_W-1:0] pa_r, pa_nxt;
  logic                       acc_r, acc_nxt, wr_r, wr_nxt, tm_r, tm_nxt;
  logic                       evict_r, evict_nxt;
  logic [1:0]                 dest_r, dest_nxt;
  logic [3:0]                 cnt_r, cnt_nxt, i_r, i_nxt;
  logic [15:0]                mask_r, mask_nxt;
  logic [cwl_pkg::NUM_SETS-1:0] valid_r, valid_nxt;
  logic [1:0]                 cmode_r, cmode_nxt;
  cwl_pkg::res_t              hold_r, hold_nxt, out_r, out_nxt;
  logic                       hold_v_r, hold_v_nxt;
  logic                       out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;

  logic                       row_lb [cwl_pkg::NUM_WAYS];
  logic [cwl_pkg::ADDR_W-1:0] row_a  [cwl_pkg::NUM_WAYS];
  logic [cwl_pkg::CNT_W-1:0]  lk_cnt;
  logic                       lk_conf, lk_err;
  logic                       set_in, way_in, walk_ok, walk_end;
  logic                       s_wrap;
  logic [cwl_pkg::SET_W-1:0]  s_adv;
  logic [cwl_pkg::WAY_W-1:0]  w_adv;
  logic                       cur_lb, cur_sp, cur_act;
  logic [cwl_pkg::ADDR_W-1:0] cur_a;
  logic [1:0]                 diff;
  cwl_pkg::res_t              res;

  assign set_in  = {1'b0, in_set} < 5'(cwl_pkg::NUM_SETS);
  assign way_in  = {1'b0, in_way} < 3'(cwl_pkg::NUM_WAYS);
  assign walk_ok = (in_dest != cwl_pkg::DEST_L1) && set_in && way_in &&
                   !(in_service_proc && (in_dest != cwl_pkg::DEST_L2));
  assign diff    = cmode_r ^ in_new_cache_mode;

  // unpack the row just read; a row never written since a clear reads as zero
  always_comb begin
    for (int i = 0; i < cwl_pkg::NUM_WAYS; i++) begin
      row_lb[i] = valid_r[s_r] & ram_rdata[i];
      row_a[i]  = valid_r[s_r] ?
                  ram_rdata[cwl_pkg::NUM_WAYS + i*cwl_pkg::ADDR_W +: cwl_pkg::ADDR_W] : '0;
    end
  end

  always_comb begin
    lk_cnt  = '0;
    lk_conf = 1'b0;
    for (int i = 0; i < cwl_pkg::NUM_WAYS; i++) begin
      lk_cnt  = lk_cnt + cwl_pkg::CNT_W'(row_lb[i]);
      lk_conf = lk_conf | (row_lb[i] & ((w_r == cwl_pkg::WAY_W'(i)) || (row_a[i] == pa_r)));
    end
    lk_err = lk_conf || (lk_cnt >= cwl_pkg::CNT_W'(cwl_pkg::NUM_WAYS - 1));
  end

  // walk step on the current line
  assign s_wrap   = (s_r == cwl_pkg::SET_W'(cwl_pkg::NUM_SETS - 1));
  assign s_adv    = s_wrap ? '0 : s_r + 1'b1;
  assign w_adv    = !s_wrap ? w_r :
                    (w_r == cwl_pkg::WAY_W'(cwl_pkg::NUM_WAYS - 1)) ? '0 : w_r + 1'b1;
  assign cur_lb   = row_lb[w_r];
  assign cur_a    = row_a[w_r];
  assign cur_sp   = (dest_r >= cwl_pkg::DEST_L3) && cur_lb &&
                    (cur_a >= cfg.base) && (cur_a <= cfg.limit);
  assign cur_act  = (!tm_r || mask_r[i_r]) && !(evict_r && cur_lb);
  assign walk_end = (i_r == cnt_r) || (cur_act && cur_sp);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cwl_pkg::S_IDLE: begin
        if (start) begin
          case (in_mode) inside
            cwl_pkg::MODE_LOCK:
              state_nxt = (set_in && way_in) ? cwl_pkg::S_LOCK : cwl_pkg::S_IDLE;
            cwl_pkg::MODE_UNLOCK:
              state_nxt = (set_in && way_in) ? cwl_pkg::S_UNLK : cwl_pkg::S_IDLE;
            cwl_pkg::MODE_EVICT, cwl_pkg::MODE_FLUSH:
              state_nxt = walk_ok ? cwl_pkg::S_WALK : cwl_pkg::S_FIN;
            cwl_pkg::MODE_CHANGE: state_nxt = cwl_pkg::S_IDLE;
            default:              state_nxt = cwl_pkg::S_FIN;
          endcase
        end
      end
      cwl_pkg::S_LOCK:  state_nxt = cwl_pkg::S_IDLE;
      cwl_pkg::S_UNLK:  state_nxt = cwl_pkg::S_IDLE;
      cwl_pkg::S_WALK:  state_nxt = walk_end ? cwl_pkg::S_FIN : cwl_pkg::S_WALK;
      cwl_pkg::S_FIN:   state_nxt = cwl_pkg::S_IDLE;
      default:          state_nxt = cwl_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_nxt         = s_r;
    w_nxt         = w_r;
    pa_nxt        = pa_r;
    acc_nxt       = acc_r;
    wr_nxt        = wr_r;
    tm_nxt        = tm_r;
    evict_nxt     = evict_r;
    dest_nxt      = dest_r;
    cnt_nxt       = cnt_r;
    i_nxt         = i_r;
    mask_nxt      = mask_r;
    valid_nxt     = valid_r;
    cmode_nxt     = cmode_r;
    hold_nxt      = hold_r;
    hold_v_nxt    = hold_v_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    out_last_nxt  = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = s_r;
    ram_wdata     = '0;
    ram_raddr     = s_r;
    res           = '0;
    unique case (state_r)
      cwl_pkg::S_IDLE: begin
        ram_raddr = in_set[cwl_pkg::SET_W-1:0];
        if (start) begin
          s_nxt      = in_set[cwl_pkg::SET_W-1:0];
          w_nxt      = in_way[cwl_pkg::WAY_W-1:0];
          pa_nxt     = in_line_addr & cwl_pkg::ADDR_MASK;
          acc_nxt    = in_access_ok;
          wr_nxt     = in_write_ok;
          tm_nxt     = in_use_mask;
          evict_nxt  = (in_mode == cwl_pkg::MODE_EVICT);
          dest_nxt   = in_dest;
          cnt_nxt    = in_count_minus_one;
          mask_nxt   = in_lane_mask;
          i_nxt      = '0;
          hold_v_nxt = 1'b0;
          case (in_mode)
            cwl_pkg::MODE_LOCK: begin
              if (!(set_in && way_in)) begin
                res.op_set       = in_set;
                res.op_way       = in_way;
                res.access_error = !in_access_ok;
                res.lock_error   = 1'b1;
                out_nxt          = res;
                out_valid_nxt    = 1'b1;
                out_last_nxt     = 1'b1;
              end
            end
            cwl_pkg::MODE_UNLOCK: begin
              if (!(set_in && way_in)) begin
                res.op_set    = in_set;
                res.op_way    = in_way;
                out_nxt       = res;
                out_valid_nxt = 1'b1;
                out_last_nxt  = 1'b1;
              end
            end
            cwl_pkg::MODE_CHANGE: begin
              for (int i = 0; i < cwl_pkg::NUM_SETS; i++) begin
                if (diff[0] || (diff[1] && (i < cwl_pkg::NUM_SETS - 2))) begin
                  valid_nxt[i] = 1'b0;
                end
              end
              cmode_nxt            = in_new_cache_mode;
              res.clear_scratchpad = diff[1] && in_new_cache_mode[1];
              out_nxt              = res;
              out_valid_nxt        = 1'b1;
              out_last_nxt         = 1'b1;
            end
            default: ;
          endcase
        end
      end
      cwl_pkg::S_LOCK: begin
        res.op_set = 4'(s_r);
        res.op_way = 2'(w_r);
        if (lk_err) begin
          res.access_error = !acc_r;
          res.lock_error   = 1'b1;
        end else if (!acc_r || !wr_r) begin
          res.access_error = 1'b1;
        end else begin
          res.op_done = 1'b1;
          ram_we      = 1'b1;
          for (int i = 0; i < cwl_pkg::NUM_WAYS; i++) begin
            ram_wdata[i] = row_lb[i] | (w_r == cwl_pkg::WAY_W'(i));
            ram_wdata[cwl_pkg::NUM_WAYS + i*cwl_pkg::ADDR_W +: cwl_pkg::ADDR_W] =
              (w_r == cwl_pkg::WAY_W'(i)) ? pa_r : row_a[i];
          end
          valid_nxt[s_r] = 1'b1;
        end
        out_nxt       = res;
        out_valid_nxt = 1'b1;
        out_last_nxt  = 1'b1;
      end
      cwl_pkg::S_UNLK: begin
        // only the lock bit goes; the address stays
        ram_we = 1'b1;
        for (int i = 0; i < cwl_pkg::NUM_WAYS; i++) begin
          ram_wdata[i] = row_lb[i] & (w_r != cwl_pkg::WAY_W'(i));
          ram_wdata[cwl_pkg::NUM_WAYS + i*cwl_pkg::ADDR_W +: cwl_pkg::ADDR_W] = row_a[i];
        end
        valid_nxt[s_r] = 1'b1;
        res.op_done    = 1'b1;
        res.op_set     = 4'(s_r);
        res.op_way     = 2'(w_r);
        out_nxt        = res;
        out_valid_nxt  = 1'b1;
        out_last_nxt   = 1'b1;
      end
      cwl_pkg::S_WALK: begin
        ram_raddr = s_adv;
        res.op_set = 4'(s_r);
        res.op_way = 2'(w_r);
        if (cur_sp) begin
          res.fault_address = cur_a;
          res.bus_error     = 1'b1;
        end else begin
          res.op_done = 1'b1;
        end
        // one word stays held back so the final one can carry last
        if (cur_act) begin
          hold_nxt   = res;
          hold_v_nxt = 1'b1;
          if (hold_v_r) begin
            out_nxt       = hold_r;
            out_valid_nxt = 1'b1;
          end
        end
        s_nxt = s_adv;
        w_nxt = w_adv;
        i_nxt = i_r + 1'b1;
      end
      cwl_pkg::S_FIN: begin
        out_nxt       = hold_v_r ? hold_r : '0;
        out_valid_nxt = 1'b1;
        out_last_nxt  = 1'b1;
        hold_v_nxt    = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cwl_pkg::S_IDLE;
      valid_r     <= '0;
      cmode_r     <= '0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      out_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      cmode_r     <= cmode_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
      out_r       <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r     <= s_nxt;
    w_r     <= w_nxt;
    pa_r    <= pa_nxt;
    acc_r   <= acc_nxt;
    wr_r    <= wr_nxt;
    tm_r    <= tm_nxt;
    evict_r <= evict_nxt;
    dest_r  <= dest_nxt;
    cnt_r   <= cnt_nxt;
    i_r     <= i_nxt;
    mask_r  <= mask_nxt;
    hold_r  <= hold_nxt;
  end

  assign busy      = (state_r != cwl_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_last  = out_last_r;
  assign out_res   = out_r;

endmodule

@@ design/cache_way_lock_table.sv @@
// cache way lock table
// a request is taken when start is high and busy is low; its fields sit on
// the in_ ports in that cycle. results come back at most one word per cycle on the
// out_ ports, each marked by out_valid for exactly one cycle; out_last marks
// the final word of a request. the receiver cannot stall, so it must take
// every word in the cycle it appears.
// lock and unlock: the set row is read from the table ram and written back in
// the next cycle, where the result is registered; busy drops as the result
// appears, so the next request can follow right away.
// mode change and refused out-of-table lock/unlock requests answer straight from idle.
// evict/flush walks read one line per cycle from the ram, count_minus_one+1
// lines in all, then end in S_FIN; a bus error ends the walk early.
// scratchpad base/limit are written on the cfg_ port (always ready); the user must
// write them only while the block is idle, which the block itself does not enforce.
// reset is synchronous: all locks, the cache mode and the scratchpad range
// clear at once (per-set valid bits), with no clearing pass.
`include "assert_macros.svh"

module cache_way_lock_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_mode,
  input  logic [3:0]  in_set,
  input  logic [1:0]  in_way,
  input  logic [39:0] in_line_addr,
  input  logic        in_access_ok,
  input  logic        in_write_ok,
  input  logic [1:0]  in_dest,
  input  logic [3:0]  in_count_minus_one,
  input  logic        in_use_mask,
  input  logic [15:0] in_lane_mask,
  input  logic        in_service_proc,
  input  logic [1:0]  in_new_cache_mode,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [39:0] cfg_data,
  output logic        out_valid,
  output logic        out_op_done,
  output logic [3:0]  out_op_set,
  output logic [1:0]  out_op_way,
  output logic [39:0] out_fault_address,
  output logic        out_bus_error,
  output logic        out_access_error,
  output logic        out_lock_error,
  output logic        out_clear_scratchpad,
  output logic        out_last
);

  cwl_pkg::cfg_t cfg_r, cfg_nxt;
  cwl_pkg::res_t res;

  logic                      ram_we;
  logic [cwl_pkg::SET_W-1:0] ram_waddr, ram_raddr;
  logic [cwl_pkg::ROW_W-1:0] ram_wdata, ram_rdata;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        cwl_pkg::CFG_BASE:  cfg_nxt.base  = cfg_data;
        cwl_pkg::CFG_LIMIT: cfg_nxt.limit = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  cwl_ram #(
    .WIDTH (cwl_pkg::ROW_W),
    .DEPTH (cwl_pkg::NUM_SETS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  cwl_ctrl u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_mode            (in_mode),
    .in_set             (in_set),
    .in_way             (in_way),
    .in_line_addr       (in_line_addr),
    .in_access_ok       (in_access_ok),
    .in_write_ok        (in_write_ok),
    .in_dest            (in_dest),
    .in_count_minus_one (in_count_minus_one),
    .in_use_mask        (in_use_mask),
    .in_lane_mask       (in_lane_mask),
    .in_service_proc    (in_service_proc),
    .in_new_cache_mode  (in_new_cache_mode),
    .cfg                (cfg_r),
    .ram_we             (ram_we),
    .ram_waddr          (ram_waddr),
    .ram_wdata          (ram_wdata),
    .ram_raddr          (ram_raddr),
    .ram_rdata          (ram_rdata),
    .out_valid          (out_valid),
    .out_last           (out_last),
    .out_res            (res)
  );

  assign out_op_done          = res.op_done;
  assign out_op_set           = res.op_set;
  assign out_op_way           = res.op_way;
  assign out_fault_address    = res.fault_address;
  assign out_bus_error        = res.bus_error;
  assign out_access_error     = res.access_error;
  assign out_lock_error       = res.lock_error;
  assign out_clear_scratchpad = res.clear_scratchpad;

  `CWL_ASSERT(a_last_has_valid, out_last |-> out_valid)
  `CWL_ASSERT(a_start_answers, (start && !busy) |=> (busy || out_valid))
  `CWL_ASSERT(a_buserr_not_done, (out_valid && out_bus_error) |-> !out_op_done)
  `CWL_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> (!out_valid && !busy))

endmodule

@@ tb/sv/cache_way_lock_table_test.sv @@
`timescale 1ns / 100ps

module cache_way_lock_table_test;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_mode;
  logic [3:0]  in_set;
  logic [1:0]  in_way;
  logic [39:0] in_line_addr;
  logic        in_access_ok;
  logic        in_write_ok;
  logic [1:0]  in_dest;
  logic [3:0]  in_count_minus_one;
  logic        in_use_mask;
  logic [15:0] in_lane_mask;
  logic        in_service_proc;
  logic [1:0]  in_new_cache_mode;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [39:0] cfg_data;
  logic        out_valid;
  logic        out_op_done;
  logic [3:0]  out_op_set;
  logic [1:0]  out_op_way;
  logic [39:0] out_fault_address;
  logic        out_bus_error;
  logic        out_access_error;
  logic        out_lock_error;
  logic        out_clear_scratchpad;
  logic        out_last;

  typedef struct packed {
    logic [2:0]  mode;
    logic [3:0]  set;
    logic [1:0]  way;
    logic [39:0] line_addr;
    logic        access_ok;
    logic        write_ok;
    logic [1:0]  dest;
    logic [3:0]  count_minus_one;
    logic        use_mask;
    logic [15:0] lane_mask;
    logic        service_proc;
    logic [1:0]  new_cache_mode;
  } req_t;

  typedef struct packed {
    cwl_pkg::res_t r;
    logic          last;
  } word_t;

  localparam int ENTRIES = cwl_pkg::NUM_SETS * cwl_pkg::NUM_WAYS;

  // predictor state
  logic                       lock_bit [ENTRIES];
  logic [cwl_pkg::ADDR_W-1:0] lock_addr [ENTRIES];
  logic [1:0]                 mode_bits;
  logic [cwl_pkg::ADDR_W-1:0] sp_base, sp_limit;

  word_t expected_words[$];
  int    mismatches;
  int    words_seen;
  int    items_sent;
  int    idle_pct;

  cache_way_lock_table i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("cache_way_lock_table_test: done, errors");
    $finish;
  end

  function automatic cwl_pkg::res_t blank_res();
    cwl_pkg::res_t r;
    r = '0;
    return r;
  endfunction

  function automatic logic in_scratchpad(logic [cwl_pkg::ADDR_W-1:0] a);
    return a >= sp_base && a <= sp_limit;
  endfunction

  task automatic push_word(cwl_pkg::res_t r);
    word_t w;
    w.r = r;
    w.last = 1'b0;
    expected_words.push_back(w);
  endtask

  // works out the words one request yields and updates the lock table
  task automatic predict_table(req_t q);
    cwl_pkg::res_t r;
    int n0, s, w, e, cnt, i;
    logic [cwl_pkg::ADDR_W-1:0] pa;
    logic aerr, refused, stop;
    logic [1:0] diff;
    int lim;
    word_t t;
    n0 = expected_words.size();
    r = blank_res();
    s = int'(q.set);
    w = int'(q.way);
    case (q.mode) inside
      cwl_pkg::MODE_LOCK: begin
        pa = q.line_addr & cwl_pkg::ADDR_MASK;
        aerr = !q.access_ok;
        r.op_set = q.set;
        r.op_way = q.way;
        refused = (s >= cwl_pkg::NUM_SETS || w >= cwl_pkg::NUM_WAYS);
        cnt = 0;
        if (!refused) begin
          for (i = 0; i < cwl_pkg::NUM_WAYS; i++) begin
            e = s * cwl_pkg::NUM_WAYS + i;
            if (lock_bit[e]) begin
              cnt++;
              if (i == w || lock_addr[e] == pa) refused = 1'b1;
            end
          end
          if (cnt >= cwl_pkg::NUM_WAYS - 1) refused = 1'b1;
        end
        if (refused) begin
          r.access_error = aerr;
          r.lock_error = 1'b1;
        end else if (!q.access_ok || !q.write_ok) begin
          r.access_error = 1'b1;
        end else begin
          lock_bit[s * cwl_pkg::NUM_WAYS + w] = 1'b1;
          lock_addr[s * cwl_pkg::NUM_WAYS + w] = pa;
          r.op_done = 1'b1;
        end
        push_word(r);
      end
      cwl_pkg::MODE_UNLOCK: begin
        r.op_set = q.set;
        r.op_way = q.way;
        if (s < cwl_pkg::NUM_SETS && w < cwl_pkg::NUM_WAYS) begin
          lock_bit[s * cwl_pkg::NUM_WAYS + w] = 1'b0;
          r.op_done = 1'b1;
        end
        push_word(r);
      end
      cwl_pkg::MODE_EVICT, cwl_pkg::MODE_FLUSH: begin
        if (q.dest != cwl_pkg::DEST_L1 && s < cwl_pkg::NUM_SETS && w < cwl_pkg::NUM_WAYS &&
            !(q.dest != cwl_pkg::DEST_L2 && q.service_proc)) begin
          stop = 1'b0;
          for (i = 0; i <= q.count_minus_one && !stop; i++) begin
            e = s * cwl_pkg::NUM_WAYS + w;
            if ((!q.use_mask || q.lane_mask[i]) &&
                !(q.mode == cwl_pkg::MODE_EVICT && lock_bit[e])) begin
              r = blank_res();
              r.op_set = 4'(s);
              r.op_way = 2'(w);
              if (q.dest >= cwl_pkg::DEST_L3 && lock_bit[e] && in_scratchpad(lock_addr[e]))
              begin
                r.fault_address = lock_addr[e];
                r.bus_error = 1'b1;
                stop = 1'b1;
              end else begin
                r.op_done = 1'b1;
              end
              push_word(r);
            end
            if (++s >= cwl_pkg::NUM_SETS) begin
              s = 0;
              if (++w >= cwl_pkg::NUM_WAYS) w = 0;
            end
          end
        end
      end
      cwl_pkg::MODE_CHANGE: begin
        diff = mode_bits ^ q.new_cache_mode;
        lim = diff[0] ? cwl_pkg::NUM_SETS : (diff[1] ? cwl_pkg::NUM_SETS - 2 : 0);
        for (i = 0; i < lim * cwl_pkg::NUM_WAYS; i++) begin
          lock_bit[i] = 1'b0;
          lock_addr[i] = '0;
        end
        mode_bits = q.new_cache_mode;
        r.clear_scratchpad = diff[1] && q.new_cache_mode[1];
        push_word(r);
      end
      default: ;
    endcase
    if (expected_words.size() == n0) push_word(blank_res());
    t = expected_words[$];
    t.last = 1'b1;
    expected_words[$] = t;
  endtask

  // sends one request, idling at random beforehand
  task automatic send_request(req_t q);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    {in_mode, in_set, in_way, in_line_addr, in_access_ok, in_write_ok, in_dest,
     in_count_minus_one, in_use_mask, in_lane_mask, in_service_proc,
     in_new_cache_mode} <= q;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_table(q);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    start <= 1'b0;
    while (expected_words.size() != 0 && guard < 100000) begin
      @(negedge clk);
      guard++;
    end
    repeat (24) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [39:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == cwl_pkg::CFG_BASE) sp_base = val;
    else sp_limit = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic req_t rand_req();
    req_t q;
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    q = raw[$bits(req_t)-1:0];
    q.mode = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5)) :
             3'($urandom_range(4));
    if (q.mode == cwl_pkg::MODE_CHANGE && $urandom_range(3) != 0) q.mode = cwl_pkg::MODE_LOCK;
    q.access_ok = $urandom_range(9) != 0;
    q.write_ok = $urandom_range(9) != 0;
    // keep addresses mostly in a small pool so double locks and ranges hit
    if ($urandom_range(3) != 0) q.line_addr = {32'h0000_0010, 2'($urandom), 6'($urandom)};
    if ($urandom_range(1)) q.count_minus_one = 4'($urandom_range(3));
    return q;
  endfunction

  function automatic req_t make_req(logic [2:0] m, logic [3:0] s, logic [1:0] w);
    req_t q;
    q = '0;
    q.mode = m;
    q.set = s;
    q.way = w;
    q.access_ok = 1'b1;
    q.write_ok = 1'b1;
    q.dest = cwl_pkg::DEST_MEM;
    return q;
  endfunction

  // result checker
  always @(posedge clk) begin
    word_t got, want;
    if (rst_n && out_valid) begin
      got.r = {out_op_done, out_op_set, out_op_way, out_fault_address, out_bus_error,
               out_access_error, out_lock_error, out_clear_scratchpad};
      got.last = out_last;
      words_seen++;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", got);
      end else begin
        want = expected_words.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word mismatch: expected %h, got %h", want, got);
        end
      end
    end
  end

  task automatic test_lock_unlock();
    req_t q;
    int i;
    for (i = 0; i < 4; i++) begin
      q = make_req(cwl_pkg::MODE_LOCK, 4'd5, 2'(i));
      q.line_addr = 40'hFF_FFFF_FFFF - (i << 6);
      send_request(q);
    end
    q = make_req(cwl_pkg::MODE_LOCK, 4'd5, 2'd0);
    send_request(q);
    q = make_req(cwl_pkg::MODE_LOCK, 4'd0, 2'd0);
    q.access_ok = 1'b0;
    send_request(q);
    q = make_req(cwl_pkg::MODE_LOCK, 4'd0, 2'd1);
    q.write_ok = 1'b0;
    q.line_addr = 40'h3F;
    send_request(q);
    send_request(make_req(cwl_pkg::MODE_UNLOCK, 4'd5, 2'd1));
    send_request(make_req(cwl_pkg::MODE_UNLOCK, 4'd15, 2'd3));
    q = make_req(cwl_pkg::MODE_LOCK, 4'd15, 2'd3);
    q.line_addr = 40'h00_0000_1040;
    send_request(q);
  endtask

  task automatic test_walks();
    req_t q;
    q = make_req(cwl_pkg::MODE_FLUSH, 4'd14, 2'd3);
    q.count_minus_one = 4'd15;
    send_request(q);
    q.mode = cwl_pkg::MODE_EVICT;
    q.set = 4'd5;
    q.way = 2'd0;
    send_request(q);
    q.use_mask = 1'b1;
    q.lane_mask = 16'hA5C3;
    send_request(q);
    q.dest = cwl_pkg::DEST_L1;
    send_request(q);
    q.dest = cwl_pkg::DEST_L3;
    q.service_proc = 1'b1;
    send_request(q);
    q = make_req(cwl_pkg::MODE_FLUSH, 4'd5, 2'd0);
    q.count_minus_one = 4'd15;
    send_request(q);
    send_request(make_req(3'd7, 4'd0, 2'd0));
  endtask

  task automatic test_mode_change();
    req_t q;
    q = make_req(cwl_pkg::MODE_CHANGE, 4'd0, 2'd0);
    q.new_cache_mode = 2'b10;
    send_request(q);
    q.new_cache_mode = 2'b11;
    send_request(q);
    q.new_cache_mode = 2'b11;
    send_request(q);
    q.new_cache_mode = 2'b00;
    send_request(q);
  endtask

  task automatic test_random(int n);
    req_t q;
    int i;
    for (i = 0; i < n; i++) begin
      q = rand_req();
      send_request(q);
      if (i == n / 2) drain();
    end
  endtask

  initial begin
    int i;
    rst_n = 1'b0;
    start = 1'b0;
    {in_mode, in_set, in_way, in_line_addr, in_access_ok, in_write_ok, in_dest,
     in_count_minus_one, in_use_mask, in_lane_mask, in_service_proc,
     in_new_cache_mode} = '0;
    cfg_valid = 1'b0;
    cfg_index = cwl_pkg::CFG_BASE;
    cfg_data = '0;
    mismatches = 0;
    words_seen = 0;
    items_sent = 0;
    idle_pct = 28;
    mode_bits = '0;
    sp_base = '0;
    sp_limit = '0;
    for (i = 0; i < ENTRIES; i++) begin
      lock_bit[i] = 1'b0;
      lock_addr[i] = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_lock_unlock();
    test_walks();
    write_reg(cwl_pkg::CFG_BASE, 40'h0);
    write_reg(cwl_pkg::CFG_LIMIT, 40'hFF_FFFF_FFFF);
    test_walks();
    test_mode_change();
    write_reg(cwl_pkg::CFG_BASE, 40'h00_0000_1000);
    write_reg(cwl_pkg::CFG_LIMIT, 40'h00_0000_10FF);
    test_random(130);
    idle_pct = 0;
    test_random(100);
    idle_pct = 28;
    write_reg(cwl_pkg::CFG_BASE, 40'hFF_FFFF_FFFF);
    write_reg(cwl_pkg::CFG_LIMIT, 40'h0);
    test_random(60);
    write_reg(cwl_pkg::CFG_BASE, 40'h00_0000_1040);
    write_reg(cwl_pkg::CFG_LIMIT, 40'hFF_FFFF_FFFF);
    test_random(60);
    drain();

    $display("covered %0d requests, %0d result words: locks, unlocks, walks, mode changes",
             items_sent, words_seen);
    $display("scratchpad range set to empty, full and partial settings");
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("cache_way_lock_table_test: done, clean");
    end else begin
      $display("cache_way_lock_table_test: done, errors");
    end
    $finish;
  end

endmodule
